### rtl/i8080_alu_pkg.sv
package i8080_alu_pkg;

    // Operation codes carried in the func field
    typedef enum logic [4:0] {
        FUNC_ADD  = 5'd0,
        FUNC_ADC  = 5'd1,
        FUNC_SUB  = 5'd2,
        FUNC_SBB  = 5'd3,
        FUNC_ANA  = 5'd4,
        FUNC_XRA  = 5'd5,
        FUNC_ORA  = 5'd6,
        FUNC_CMP  = 5'd7,
        FUNC_INR  = 5'd8,
        FUNC_DCR  = 5'd9,
        FUNC_DAA  = 5'd10,
        FUNC_RLC  = 5'd11,
        FUNC_RRC  = 5'd12,
        FUNC_RAL  = 5'd13,
        FUNC_RAR  = 5'd14,
        FUNC_CMA  = 5'd15,
        FUNC_STC  = 5'd16,
        FUNC_CMC  = 5'd17,
        FUNC_LOAD = 5'd18,
        FUNC_PSW  = 5'd19
    } func_t;

    // Flag byte bit positions: S Z 0 AC 0 P 1 C
    localparam int unsigned FLAG_S   = 7;
    localparam int unsigned FLAG_Z   = 6;
    localparam int unsigned FLAG_AC  = 4;
    localparam int unsigned FLAG_P   = 2;
    localparam int unsigned FLAG_C   = 0;

    localparam logic [7:0] ACC_RESET   = 8'h00;
    localparam logic [7:0] FLAGS_RESET = 8'h02;
    localparam logic [7:0] PSW_SET     = 8'h02;
    localparam logic [7:0] PSW_MASK    = 8'hD7;

    // Architectural state seen by the datapath
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] flags;
    } alu_state_t;

    // One result beat
    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] acc;
        logic [7:0] result;
    } alu_out_t;

endpackage

### rtl/i8080_alu_core.sv
module i8080_alu_core (
    input  logic [4:0]                 func,
    input  logic [7:0]                 operand_byte,
    input  logic [7:0]                 flags_in,
    input  i8080_alu_pkg::alu_state_t  state,
    output i8080_alu_pkg::alu_out_t    outcome
);

    logic       is_sub;
    logic       cin;
    logic [7:0] b_eff;
    logic [8:0] sum9;
    logic [4:0] low5;
    logic       add_ac;
    logic       add_cy;
    logic [7:0] inr_v;
    logic [7:0] dcr_v;
    logic [3:0] lo;
    logic [3:0] hi;
    logic       lo_big;
    logic       daa_cy;
    logic [7:0] daa_corr;
    logic [7:0] acc_new;
    logic [7:0] res_v;
    logic       ac_new;
    logic       cy_new;
    logic       szp_upd;
    logic [7:0] szp_v;
    logic       psw;
    logic       cy_old;
    logic       sign_new;
    logic       zero_new;
    logic       par_new;

    assign cy_old = state.flags[i8080_alu_pkg::FLAG_C];

    // Shared 8-bit adder for add, subtract and compare
    always_comb
    begin
        is_sub = (func == i8080_alu_pkg::FUNC_SUB) || (func == i8080_alu_pkg::FUNC_SBB)
              || (func == i8080_alu_pkg::FUNC_CMP);
        b_eff  = is_sub ? ~operand_byte : operand_byte;
        unique case (func)
            i8080_alu_pkg::FUNC_ADC: cin = cy_old;
            i8080_alu_pkg::FUNC_SUB: cin = 1'b1;
            i8080_alu_pkg::FUNC_SBB: cin = ~cy_old;
            i8080_alu_pkg::FUNC_CMP: cin = 1'b1;
            default:                 cin = 1'b0;
        endcase
        sum9   = 9'(state.acc) + 9'(b_eff) + 9'(cin);
        low5   = 5'(state.acc[3:0]) + 5'(b_eff[3:0]) + 5'(cin);
        add_ac = low5[4];
        add_cy = sum9[8] ^ is_sub;
    end

    assign inr_v = operand_byte + 8'd1;
    assign dcr_v = operand_byte - 8'd1;

    // Decimal adjust
    always_comb
    begin
        lo       = state.acc[3:0];
        hi       = state.acc[7:4];
        lo_big   = (lo > 4'd9);
        daa_corr = 8'h00;
        daa_cy   = cy_old;
        if (lo_big || state.flags[i8080_alu_pkg::FLAG_AC])
        begin
            daa_corr[3:0] = 4'h6;
        end
        if ((hi > 4'd9) || cy_old || ((hi >= 4'd9) && lo_big))
        begin
            daa_corr[7:4] = 4'h6;
            daa_cy        = 1'b1;
        end
    end

    always_comb
    begin
        acc_new = state.acc;
        res_v   = state.acc;
        ac_new  = state.flags[i8080_alu_pkg::FLAG_AC];
        cy_new  = cy_old;
        szp_upd = 1'b0;
        szp_v   = state.acc;
        psw     = 1'b0;
        unique case (func)
            i8080_alu_pkg::FUNC_ADD, i8080_alu_pkg::FUNC_ADC,
            i8080_alu_pkg::FUNC_SUB, i8080_alu_pkg::FUNC_SBB:
            begin
                acc_new = sum9[7:0];
                ac_new  = add_ac;
                cy_new  = add_cy;
                szp_upd = 1'b1;
                szp_v   = sum9[7:0];
            end
            i8080_alu_pkg::FUNC_CMP:
            begin
                ac_new  = add_ac;
                cy_new  = add_cy;
                szp_upd = 1'b1;
                szp_v   = sum9[7:0];
            end
            i8080_alu_pkg::FUNC_ANA:
            begin
                acc_new = state.acc & operand_byte;
                ac_new  = state.acc[3] | operand_byte[3];
                cy_new  = 1'b0;
                szp_upd = 1'b1;
                szp_v   = state.acc & operand_byte;
            end
            i8080_alu_pkg::FUNC_XRA:
            begin
                acc_new = state.acc ^ operand_byte;
                ac_new  = 1'b0;
                cy_new  = 1'b0;
                szp_upd = 1'b1;
                szp_v   = state.acc ^ operand_byte;
            end
            i8080_alu_pkg::FUNC_ORA:
            begin
                acc_new = state.acc | operand_byte;
                ac_new  = 1'b0;
                cy_new  = 1'b0;
                szp_upd = 1'b1;
                szp_v   = state.acc | operand_byte;
            end
            i8080_alu_pkg::FUNC_INR:
            begin
                szp_upd = 1'b1;
                szp_v   = inr_v;
                ac_new  = (inr_v[3:0] == 4'h0);
            end
            i8080_alu_pkg::FUNC_DCR:
            begin
                szp_upd = 1'b1;
                szp_v   = dcr_v;
                ac_new  = (dcr_v[3:0] != 4'hF);
            end
            i8080_alu_pkg::FUNC_DAA:
            begin
                acc_new = state.acc + daa_corr;
                ac_new  = lo_big;
                cy_new  = daa_cy;
                szp_upd = 1'b1;
                szp_v   = state.acc + daa_corr;
            end
            i8080_alu_pkg::FUNC_RLC:
            begin
                acc_new = {state.acc[6:0], state.acc[7]};
                cy_new  = state.acc[7];
            end
            i8080_alu_pkg::FUNC_RRC:
            begin
                acc_new = {state.acc[0], state.acc[7:1]};
                cy_new  = state.acc[0];
            end
            i8080_alu_pkg::FUNC_RAL:
            begin
                acc_new = {state.acc[6:0], cy_old};
                cy_new  = state.acc[7];
            end
            i8080_alu_pkg::FUNC_RAR:
            begin
                acc_new = {cy_old, state.acc[7:1]};
                cy_new  = state.acc[0];
            end
            i8080_alu_pkg::FUNC_CMA:  acc_new = ~state.acc;
            i8080_alu_pkg::FUNC_STC:  cy_new  = 1'b1;
            i8080_alu_pkg::FUNC_CMC:  cy_new  = ~cy_old;
            i8080_alu_pkg::FUNC_LOAD: acc_new = operand_byte;
            i8080_alu_pkg::FUNC_PSW:
            begin
                acc_new = operand_byte;
                psw     = 1'b1;
            end
            default:
            begin
                acc_new = state.acc;
            end
        endcase

        // result follows the accumulator except for the inc/dec side path
        if (func == i8080_alu_pkg::FUNC_INR)
        begin
            res_v = inr_v;
        end
        else if (func == i8080_alu_pkg::FUNC_DCR)
        begin
            res_v = dcr_v;
        end
        else
        begin
            res_v = acc_new;
        end
    end

    always_comb
    begin
        sign_new = szp_upd ? szp_v[7]          : state.flags[i8080_alu_pkg::FLAG_S];
        zero_new = szp_upd ? (szp_v == 8'h00)  : state.flags[i8080_alu_pkg::FLAG_Z];
        par_new  = szp_upd ? ~(^szp_v)         : state.flags[i8080_alu_pkg::FLAG_P];
        outcome.result = res_v;
        outcome.acc    = acc_new;
        if (psw)
        begin
            outcome.flags = (flags_in | i8080_alu_pkg::PSW_SET) & i8080_alu_pkg::PSW_MASK;
        end
        else
        begin
            outcome.flags = {sign_new, zero_new, 1'b0, ac_new, 1'b0, par_new, 1'b1, cy_new};
        end
    end

endmodule

### rtl/i8080_accumulator_alu_top.sv
// Each accepted input beat goes through the input register, then the result register, to m_tvalid.
// Throughput: one beat per cycle unless m_tready stalls the result register; the accumulator
// and flag byte are written at the same edge as the result register, so the next beat in the
// input register sees them. Reset (rst_n low, asynchronous): accumulator to 0x00, flag byte
// to 0x02, both pipeline stages emptied.
module i8080_accumulator_alu_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [4:0] func, [12:5] operand_byte, [20:13] flags_in, [23:21] 0
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] result, [15:8] accumulator_out, [23:16] flags_out
);

    // Input register stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [4:0] in_func_reg;
    logic [7:0] in_operand_reg;
    logic [7:0] in_flags_reg;

    // Architectural state
    logic [7:0] acc_reg;
    logic [7:0] flag_reg;

    // Result register stage
    logic                    out_valid_reg;
    logic                    out_valid_next;
    i8080_alu_pkg::alu_out_t out_data_reg;

    i8080_alu_pkg::alu_state_t state;
    i8080_alu_pkg::alu_out_t   outcome;

    logic s_accept;
    logic advance;

    // Move the held beat into the result register whenever that register is free
    // or being drained this cycle.
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    assign state.acc   = acc_reg;
    assign state.flags = flag_reg;

    i8080_alu_core u_core (
        .func         (in_func_reg),
        .operand_byte (in_operand_reg),
        .flags_in     (in_flags_reg),
        .state        (state),
        .outcome      (outcome)
    );

    always_comb
    begin
        priority if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= i8080_alu_pkg::ACC_RESET;
            flag_reg      <= i8080_alu_pkg::FLAGS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                acc_reg  <= outcome.acc;
                flag_reg <= outcome.flags;
            end
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg    <= s_tdata[4:0];
            in_operand_reg <= s_tdata[12:5];
            in_flags_reg   <= s_tdata[20:13];
        end
        if (advance)
        begin
            out_data_reg <= outcome;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/i8080_alu_checker.sv
module i8080_alu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Fixed bits of the flag byte: bit 1 high, bits 3 and 5 low
    a_flag_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17] == 1'b1) && (m_tdata[19] == 1'b0) && (m_tdata[21] == 1'b0))
        else $error("flag byte fixed bits wrong");

    // An empty result register must never hold off the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Stalled result beat holds
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind i8080_accumulator_alu_top i8080_alu_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/i8080_accumulator_alu_top_tb.sv
`timescale 1ns / 100ps

module i8080_accumulator_alu_top_tb;

    // Scoreboard: mirrors the accumulator and flag byte, queues the expected
    // result beat for every accepted input beat, and checks each output beat
    // against the oldest entry.
    class acc_flag_scoreboard;
        logic [7:0]              acc;
        logic [7:0]              flags;
        i8080_alu_pkg::alu_out_t expected_results[$];
        int                      mismatches;

        function new();
            acc        = i8080_alu_pkg::ACC_RESET;
            flags      = i8080_alu_pkg::FLAGS_RESET;
            mismatches = 0;
        endfunction

        // Sign, zero and even parity of a produced byte
        function void set_szp(logic [7:0] v);
            flags[i8080_alu_pkg::FLAG_S] = v[7];
            flags[i8080_alu_pkg::FLAG_Z] = (v == 8'h00);
            flags[i8080_alu_pkg::FLAG_P] = ~^v;
        endfunction

        // Work out the next accumulator and flag byte for one operation
        function i8080_alu_pkg::alu_out_t predict_alu(logic [4:0] op, logic [7:0] n,
                                                      logic [7:0] fin);
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] res;
            logic [7:0] corr;
            logic [8:0] sum;
            logic [4:0] low;
            logic [3:0] lo;
            logic [3:0] hi;
            logic       cy;
            logic       cin;
            logic       is_sub;
            logic       newc;
            logic       side;
            a    = acc;
            cy   = flags[i8080_alu_pkg::FLAG_C];
            side = 1'b0;
            res  = 8'h00;
            case (op)
                i8080_alu_pkg::FUNC_ADD, i8080_alu_pkg::FUNC_ADC, i8080_alu_pkg::FUNC_SUB,
                i8080_alu_pkg::FUNC_SBB, i8080_alu_pkg::FUNC_CMP:
                begin
                    // subtraction adds the complement with the inverted borrow
                    is_sub = (op != i8080_alu_pkg::FUNC_ADD) && (op != i8080_alu_pkg::FUNC_ADC);
                    b      = is_sub ? ~n : n;
                    cin    = (op == i8080_alu_pkg::FUNC_ADC) ? cy :
                             (op == i8080_alu_pkg::FUNC_SBB) ? ~cy :
                             (op == i8080_alu_pkg::FUNC_ADD) ? 1'b0 : 1'b1;
                    sum    = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                    low    = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                    flags[i8080_alu_pkg::FLAG_AC] = low[4];
                    flags[i8080_alu_pkg::FLAG_C]  = is_sub ? ~sum[8] : sum[8];
                    set_szp(sum[7:0]);
                    if (op != i8080_alu_pkg::FUNC_CMP)
                    begin
                        a = sum[7:0];
                    end
                end
                i8080_alu_pkg::FUNC_ANA:
                begin
                    flags[i8080_alu_pkg::FLAG_AC] = a[3] | n[3];
                    flags[i8080_alu_pkg::FLAG_C]  = 1'b0;
                    a = a & n;
                    set_szp(a);
                end
                i8080_alu_pkg::FUNC_XRA, i8080_alu_pkg::FUNC_ORA:
                begin
                    flags[i8080_alu_pkg::FLAG_AC] = 1'b0;
                    flags[i8080_alu_pkg::FLAG_C]  = 1'b0;
                    a = (op == i8080_alu_pkg::FUNC_XRA) ? (a ^ n) : (a | n);
                    set_szp(a);
                end
                i8080_alu_pkg::FUNC_INR:
                begin
                    res = n + 8'h01;
                    set_szp(res);
                    flags[i8080_alu_pkg::FLAG_AC] = (res[3:0] == 4'h0);
                    side = 1'b1;
                end
                i8080_alu_pkg::FUNC_DCR:
                begin
                    res = n - 8'h01;
                    set_szp(res);
                    flags[i8080_alu_pkg::FLAG_AC] = (res[3:0] != 4'hF);
                    side = 1'b1;
                end
                i8080_alu_pkg::FUNC_DAA:
                begin
                    lo   = a[3:0];
                    hi   = a[7:4];
                    corr = 8'h00;
                    newc = cy;
                    if (lo > 4'd9 || flags[i8080_alu_pkg::FLAG_AC])
                    begin
                        corr = corr | 8'h06;
                    end
                    if (hi > 4'd9 || newc || (hi >= 4'd9 && lo > 4'd9))
                    begin
                        corr = corr | 8'h60;
                        newc = 1'b1;
                    end
                    flags[i8080_alu_pkg::FLAG_AC] = (lo > 4'd9);
                    flags[i8080_alu_pkg::FLAG_C]  = newc;
                    a = a + corr;
                    set_szp(a);
                end
                i8080_alu_pkg::FUNC_RLC:
                begin
                    flags[i8080_alu_pkg::FLAG_C] = a[7];
                    a = {a[6:0], a[7]};
                end
                i8080_alu_pkg::FUNC_RRC:
                begin
                    flags[i8080_alu_pkg::FLAG_C] = a[0];
                    a = {a[0], a[7:1]};
                end
                i8080_alu_pkg::FUNC_RAL:
                begin
                    flags[i8080_alu_pkg::FLAG_C] = a[7];
                    a = {a[6:0], cy};
                end
                i8080_alu_pkg::FUNC_RAR:
                begin
                    flags[i8080_alu_pkg::FLAG_C] = a[0];
                    a = {cy, a[7:1]};
                end
                i8080_alu_pkg::FUNC_CMA:  a = ~a;
                i8080_alu_pkg::FUNC_STC:  flags[i8080_alu_pkg::FLAG_C] = 1'b1;
                i8080_alu_pkg::FUNC_CMC:  flags[i8080_alu_pkg::FLAG_C] = ~cy;
                i8080_alu_pkg::FUNC_LOAD: a = n;
                i8080_alu_pkg::FUNC_PSW:
                begin
                    a     = n;
                    flags = (fin | i8080_alu_pkg::PSW_SET) & i8080_alu_pkg::PSW_MASK;
                end
                default: ;  // unused codes leave the state alone
            endcase
            acc = a;
            if (!side)
            begin
                res = a;
            end
            return i8080_alu_pkg::alu_out_t'{flags: flags, acc: a, result: res};
        endfunction

        function void note_beat(logic [4:0] op, logic [7:0] n, logic [7:0] fin);
            expected_results.push_back(predict_alu(op, n, fin));
        endfunction

        task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
            mismatches++;
            $display("%0t: MISMATCH %s got %06h expected %06h", $realtime, what, got, want);
        endtask

        task check_beat(logic [23:0] data);
            i8080_alu_pkg::alu_out_t got;
            i8080_alu_pkg::alu_out_t want;
            got = i8080_alu_pkg::alu_out_t'(data);
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", data, 24'h000000);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.result !== want.result)
                    report_mismatch("result", {16'h0000, got.result}, {16'h0000, want.result});
                if (got.acc !== want.acc)
                    report_mismatch("accumulator_out", {16'h0000, got.acc},
                                    {16'h0000, want.acc});
                if (got.flags !== want.flags)
                    report_mismatch("flags_out", {16'h0000, got.flags}, {16'h0000, want.flags});
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    localparam int RANDOM_BEATS = 1600;
    localparam int QUIET_BEATS  = 200;   // closing stretch with no idling on either side
    localparam int HOLD_AFTER   = 400;   // accepted beats before the long receiver hold-off
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [4:0] func, [12:5] operand_byte, [20:13] flags_in, [23:21] 0
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] result, [15:8] accumulator_out, [23:16] flags_out

    acc_flag_scoreboard sb = new();
    int   accepted_beats = 0;
    logic quiet = 1'b0;      // set for the closing stretch: no gaps, no stalls

    i8080_accumulator_alu_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Offer one input beat. Called at a falling edge; returns at the falling
    // edge after the beat is taken. An optional gap drops tvalid before the
    // beat goes out.
    task send_beat(logic [4:0] op, logic [7:0] n, logic [7:0] fin, logic allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, fin, n, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(op, n, fin);
        accepted_beats++;
        @(negedge clk);
    endtask

    // Operand with extra weight on the boundary bytes
    function logic [7:0] pick_operand();
        logic [7:0] edges[8];
        edges = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h80, 8'h7F, 8'h99, 8'h09};
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Check every result beat taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_beat(m_tdata);
        end
    end

    // Receiver: random stall bursts, one long hold-off once the pipe is busy,
    // and a steady tready for the closing stretch.
    initial
    begin
        logic held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                m_tready = 1'b1;
            end
            else if (!held_off && accepted_beats >= HOLD_AFTER)
            begin
                // hold off long enough for the block to fill and stall its input
                held_off = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if ((accepted_beats / 100) % 3 != 2 && $urandom_range(0, 3) == 0)
            begin
                // every third block of a hundred beats runs without stalls
                m_tready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [4:0] op;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every operation, boundary operands, the PSW mask,
        // decimal adjust needing both corrections, unused codes.
        send_beat(i8080_alu_pkg::FUNC_PSW,  8'hFF, 8'hFF, 1'b0);   // bits 3 and 5 cleared
        send_beat(i8080_alu_pkg::FUNC_PSW,  8'h00, 8'h00, 1'b1);   // bit 1 still set
        send_beat(i8080_alu_pkg::FUNC_LOAD, 8'h9B, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_DAA,  8'h00, 8'h00, 1'b1);   // low above 9, high 9
        send_beat(i8080_alu_pkg::FUNC_ADD,  8'hFF, 8'h00, 1'b0);   // carry out of 7 and 3
        send_beat(i8080_alu_pkg::FUNC_ADC,  8'h01, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_SUB,  8'h01, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_SBB,  8'hFF, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_ANA,  8'h08, 8'h00, 1'b0);   // half carry from OR
        send_beat(i8080_alu_pkg::FUNC_XRA,  8'hFF, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_ORA,  8'h00, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_CMP,  8'h80, 8'h00, 1'b1);   // accumulator unchanged
        send_beat(i8080_alu_pkg::FUNC_INR,  8'hFF, 8'h00, 1'b0);   // wraps to zero
        send_beat(i8080_alu_pkg::FUNC_DCR,  8'h00, 8'h00, 1'b1);   // wraps to 0xFF
        send_beat(i8080_alu_pkg::FUNC_INR,  8'h0F, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_DCR,  8'h10, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_RLC,  8'h00, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_RRC,  8'h00, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_RAL,  8'h00, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_RAR,  8'h00, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_CMA,  8'h00, 8'h00, 1'b0);
        send_beat(i8080_alu_pkg::FUNC_STC,  8'h00, 8'h00, 1'b1);
        send_beat(i8080_alu_pkg::FUNC_CMC,  8'h00, 8'h00, 1'b0);
        send_beat(5'd20,                    8'hA5, 8'h5A, 1'b1);   // unused codes: no-ops
        send_beat(5'd31,                    8'hFF, 8'hFF, 1'b0);

        // Random: mostly defined operations, a few unused codes; PSW restores
        // seed random carry and half carry ahead of the flag-dependent ops.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == RANDOM_BEATS - QUIET_BEATS)
            begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 99) < 6)
                op = 5'($urandom_range(20, 31));
            else
                op = 5'($urandom_range(i8080_alu_pkg::FUNC_ADD, i8080_alu_pkg::FUNC_PSW));
            send_beat(op, pick_operand(), 8'($urandom_range(0, 255)), !quiet);
        end
        s_tvalid = 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
